// ===== rtl/dcs_pkg.sv =====
// Shared types, constants and code table for the DCS Golay (23,12) codec.
package dcs_pkg;

    localparam int WORD_W    = 23;
    localparam int DATA_W    = 12;
    localparam int PAR_W     = WORD_W - DATA_W;
    localparam int CODE_W    = 9;
    localparam int IDX_W     = 7;
    localparam int ROT_W     = $clog2(WORD_W);
    localparam int STEP_W    = $clog2(DATA_W + 1);
    localparam int CODE_COUNT = 104;

    // One division step per data bit
    localparam int PAR_STEPS = DATA_W;

    localparam logic [DATA_W-1:0] PAR_POLY = 12'h8EA;
    localparam logic [2:0]        MARKER   = 3'b100;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [CODE_W-1:0] CODE_ROM [CODE_COUNT] = '{
        9'h013, 9'h015, 9'h016, 9'h019, 9'h01A, 9'h01E, 9'h023, 9'h027,
        9'h029, 9'h02B, 9'h02C, 9'h035, 9'h039, 9'h03A, 9'h03B, 9'h03C,
        9'h04C, 9'h04D, 9'h04E, 9'h052, 9'h055, 9'h059, 9'h05A, 9'h05C,
        9'h063, 9'h065, 9'h06A, 9'h06D, 9'h06E, 9'h072, 9'h075, 9'h07A,
        9'h07C, 9'h085, 9'h08A, 9'h093, 9'h095, 9'h096, 9'h0A3, 9'h0A4,
        9'h0A5, 9'h0A6, 9'h0A9, 9'h0AA, 9'h0AD, 9'h0B1, 9'h0B3, 9'h0B5,
        9'h0B6, 9'h0B9, 9'h0BC, 9'h0C6, 9'h0C9, 9'h0CD, 9'h0D5, 9'h0D9,
        9'h0DA, 9'h0E3, 9'h0E6, 9'h0E9, 9'h0EE, 9'h0F4, 9'h0F5, 9'h0F9,
        9'h109, 9'h10A, 9'h10B, 9'h113, 9'h119, 9'h11A, 9'h125, 9'h126,
        9'h12A, 9'h12C, 9'h12D, 9'h132, 9'h134, 9'h135, 9'h136, 9'h143,
        9'h146, 9'h14E, 9'h153, 9'h156, 9'h15A, 9'h166, 9'h175, 9'h186,
        9'h18A, 9'h194, 9'h197, 9'h199, 9'h19A, 9'h1AC, 9'h1B2, 9'h1B4,
        9'h1C3, 9'h1CA, 9'h1D3, 9'h1D9, 9'h1DA, 9'h1DC, 9'h1E3, 9'h1EC
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENC,
        ST_SCAN,
        ST_CHECK,
        ST_FINISH
    } state_t;

    // Status of the parity unit towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } par_status_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } lookup_t;

    // Forward table read; indexes past the table give zero
    function automatic logic [CODE_W-1:0] code_of(input logic [IDX_W-1:0] idx);
        logic [CODE_W-1:0] code;
        code = '0;
        if (int'(idx) < CODE_COUNT)
        begin
            code = CODE_ROM[idx];
        end
        return code;
    endfunction

    // Reverse table search; codes are unique so the matches OR together
    function automatic lookup_t index_of(input logic [CODE_W-1:0] code);
        lookup_t res;
        res = '0;
        for (int j = 0; j < CODE_COUNT; j++)
        begin
            if (CODE_ROM[IDX_W'(j)] == code)
            begin
                res.hit = 1'b1;
                res.idx = res.idx | IDX_W'(j);
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/dcs_parity.sv =====
// Bit-serial Golay parity generator: one division step per clock.
module dcs_parity
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dcs_pkg::DATA_W-1:0]    data,
    output dcs_pkg::par_status_t          status,
    output logic [dcs_pkg::PAR_W-1:0]     parity
);

    logic [dcs_pkg::DATA_W-1:0] rem_reg;
    logic [dcs_pkg::DATA_W-1:0] rem_next;
    logic [dcs_pkg::STEP_W-1:0] step_reg;
    logic [dcs_pkg::STEP_W-1:0] step_next;
    logic                       busy_reg;
    logic                       busy_next;
    logic                       done_reg;
    logic                       done_next;

    // Load on start, then shift and fold in the polynomial once per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = data;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = {rem_reg[dcs_pkg::DATA_W-2:0], 1'b0}
                       ^ (rem_reg[dcs_pkg::DATA_W-1] ? dcs_pkg::PAR_POLY : '0);
            step_next = step_reg + 1'b1;
            if (step_reg == dcs_pkg::STEP_W'(dcs_pkg::PAR_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign parity      = rem_reg[dcs_pkg::DATA_W-1:1];

endmodule

// ===== rtl/dcs_golay_codec.sv =====
// Top level of the DCS Golay (23,12) encoder and rotation-search decoder.
// One word in, one word out. Encode goes from acceptance to the result
// register through ST_ENC, where the serial divider runs its 12 parity
// steps, and ST_FINISH; an index beyond the table goes straight to
// ST_FINISH with found low. Decode walks the 23 rotations one per cycle;
// every rotation whose marker and low nine bits hit the code table holds
// the walk while the serial divider runs the parity check. A new word is
// taken as soon as the previous result sits in the output register, even
// while that result is stalled.
module dcs_golay_codec
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [dcs_pkg::IDX_W-1:0]     code_index,
    input  logic                          inverted,
    input  logic [dcs_pkg::WORD_W-1:0]    received_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dcs_pkg::WORD_W-1:0]    golay_word,
    output logic [dcs_pkg::IDX_W-1:0]     found_index,
    output logic                          found
);

    localparam logic [dcs_pkg::ROT_W-1:0] LAST_ROT = dcs_pkg::ROT_W'(dcs_pkg::WORD_W - 1);

    dcs_pkg::state_t              state_reg;
    dcs_pkg::state_t              state_next;
    logic [dcs_pkg::WORD_W-1:0]   word_reg;
    logic [dcs_pkg::WORD_W-1:0]   word_next;
    logic [dcs_pkg::IDX_W-1:0]    idx_reg;
    logic [dcs_pkg::IDX_W-1:0]    idx_next;
    logic                         inv_reg;
    logic                         inv_next;
    logic                         found_reg;
    logic                         found_next;
    logic [dcs_pkg::ROT_W-1:0]    rot_reg;
    logic [dcs_pkg::ROT_W-1:0]    rot_next;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [dcs_pkg::WORD_W-1:0]   out_word_reg;
    logic [dcs_pkg::WORD_W-1:0]   out_word_next;
    logic [dcs_pkg::IDX_W-1:0]    out_idx_reg;
    logic [dcs_pkg::IDX_W-1:0]    out_idx_next;
    logic                         out_found_reg;
    logic                         out_found_next;

    logic                         par_start;
    logic [dcs_pkg::DATA_W-1:0]   par_data;
    dcs_pkg::par_status_t         par_status;
    logic [dcs_pkg::PAR_W-1:0]    parity;

    logic                         out_free;
    logic                         marker_ok;
    dcs_pkg::lookup_t             lookup;
    logic [dcs_pkg::WORD_W-1:0]   rot_word;

    dcs_parity u_parity
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (par_start),
        .data   (par_data),
        .status (par_status),
        .parity (parity)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign marker_ok = (word_reg[dcs_pkg::DATA_W-1:dcs_pkg::CODE_W] == dcs_pkg::MARKER);
    assign lookup    = dcs_pkg::index_of(word_reg[dcs_pkg::CODE_W-1:0]);
    assign rot_word  = {word_reg[0], word_reg[dcs_pkg::WORD_W-1:1]};

    // Sequence encode and the rotation search
    always_comb
    begin
        state_next = state_reg;
        word_next  = word_reg;
        idx_next   = idx_reg;
        inv_next   = inv_reg;
        found_next = found_reg;
        rot_next   = rot_reg;
        par_start  = 1'b0;
        par_data   = word_reg[dcs_pkg::DATA_W-1:0];
        in_stall   = (state_reg != dcs_pkg::ST_IDLE);

        unique case (state_reg)
            dcs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode == dcs_pkg::MODE_DECODE)
                    begin
                        word_next  = received_word;
                        rot_next   = '0;
                        state_next = dcs_pkg::ST_SCAN;
                    end
                    else
                    begin
                        idx_next = code_index;
                        inv_next = inverted;
                        if (int'(code_index) < dcs_pkg::CODE_COUNT)
                        begin
                            par_start  = 1'b1;
                            par_data   = {dcs_pkg::MARKER, dcs_pkg::code_of(code_index)};
                            word_next  = {{dcs_pkg::PAR_W{1'b0}}, par_data};
                            state_next = dcs_pkg::ST_ENC;
                        end
                        else
                        begin
                            word_next  = '0;
                            found_next = 1'b0;
                            state_next = dcs_pkg::ST_FINISH;
                        end
                    end
                end
            end

            dcs_pkg::ST_ENC:
            begin
                // Append parity and apply the inversion
                if (par_status.done)
                begin
                    word_next  = {parity, word_reg[dcs_pkg::DATA_W-1:0]}
                                 ^ {dcs_pkg::WORD_W{inv_reg}};
                    found_next = 1'b1;
                    state_next = dcs_pkg::ST_FINISH;
                end
            end

            dcs_pkg::ST_SCAN:
            begin
                // Check this rotation, else advance to the next one
                if (marker_ok && lookup.hit)
                begin
                    idx_next   = lookup.idx;
                    par_start  = 1'b1;
                    state_next = dcs_pkg::ST_CHECK;
                end
                else if (rot_reg == LAST_ROT)
                begin
                    word_next  = '0;
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = dcs_pkg::ST_FINISH;
                end
                else
                begin
                    word_next = rot_word;
                    rot_next  = rot_reg + 1'b1;
                end
            end

            dcs_pkg::ST_CHECK:
            begin
                // Compare recomputed parity with the upper bits
                if (par_status.done)
                begin
                    if (parity == word_reg[dcs_pkg::WORD_W-1:dcs_pkg::DATA_W])
                    begin
                        found_next = 1'b1;
                        state_next = dcs_pkg::ST_FINISH;
                    end
                    else if (rot_reg == LAST_ROT)
                    begin
                        word_next  = '0;
                        idx_next   = '0;
                        found_next = 1'b0;
                        state_next = dcs_pkg::ST_FINISH;
                    end
                    else
                    begin
                        word_next  = rot_word;
                        rot_next   = rot_reg + 1'b1;
                        state_next = dcs_pkg::ST_SCAN;
                    end
                end
            end

            dcs_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = dcs_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dcs_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold the result word until the far side takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_idx_next   = out_idx_reg;
        out_found_next = out_found_reg;
        if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == dcs_pkg::ST_FINISH) && out_free)
        begin
            out_valid_next = 1'b1;
            out_word_next  = word_reg;
            out_idx_next   = idx_reg;
            out_found_next = found_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dcs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg      <= word_next;
        idx_reg       <= idx_next;
        inv_reg       <= inv_next;
        found_reg     <= found_next;
        rot_reg       <= rot_next;
        out_word_reg  <= out_word_next;
        out_idx_reg   <= out_idx_next;
        out_found_reg <= out_found_next;
    end

    assign out_valid   = out_valid_reg;
    assign golay_word  = out_word_reg;
    assign found_index = out_idx_reg;
    assign found       = out_found_reg;

endmodule
